FILE: rtl/core/fpmlp_pkg.sv
package fpmlp_pkg;

  localparam int DEF_N_FEATURES    = 16;
  localparam int DEF_HIDDEN_FIRST  = 32;
  localparam int DEF_HIDDEN_SECOND = 16;
  localparam int DEF_FRAC_BITS     = 16;

  localparam int N_CLASSES = 2;
  localparam int DIV_CELLS = 64;
  localparam int FIDX_W    = 6;
  localparam int VAL_W     = 64;
  localparam int WORD_W    = 32;
  localparam int IDX_W     = 11;

  typedef enum logic [2:0] {
    OP_MEAN   = 3'd0,
    OP_SCALE  = 3'd1,
    OP_BIAS   = 3'd2,
    OP_WEIGHT = 3'd3,
    OP_SAMPLE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    LAYER_IN  = 2'd0,
    LAYER_MID = 2'd1,
    LAYER_OUT = 2'd2
  } layer_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              vld;
    logic [VAL_W:0]    rem;
    logic [VAL_W-1:0]  num;
    logic [VAL_W-1:0]  den;
    logic [VAL_W-1:0]  quo;
    logic              neg;
    logic              zero;
    logic [FIDX_W-1:0] idx;
  } div_t;

  typedef struct packed {
    logic              vld;
    logic [FIDX_W-1:0] idx;
    logic [WORD_W-1:0] val;
  } div_res_t;

  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: rtl/core/fpmlp_div_cell.sv
module fpmlp_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  fpmlp_pkg::div_t  cell_in,
  output fpmlp_pkg::div_t  cell_out
);
  import fpmlp_pkg::*;

  div_t                cell_r;
  div_t                cell_nxt;
  logic [VAL_W:0]      trial;

  always_comb begin
    cell_nxt     = cell_in;
    trial        = {cell_in.rem[VAL_W-1:0], cell_in.num[VAL_W-1]};
    cell_nxt.num = {cell_in.num[VAL_W-2:0], 1'b0};
    if (trial >= {1'b0, cell_in.den}) begin
      cell_nxt.rem = trial - {1'b0, cell_in.den};
      cell_nxt.quo = {cell_in.quo[VAL_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem = trial;
      cell_nxt.quo = {cell_in.quo[VAL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

FILE: rtl/core/fpmlp_div_chain.sv
module fpmlp_div_chain #(
  parameter int FRAC_BITS = fpmlp_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [fpmlp_pkg::VAL_W-1:0]   x,
  input  logic [fpmlp_pkg::VAL_W-1:0]   mean,
  input  logic [fpmlp_pkg::VAL_W-1:0]   scale,
  input  logic [fpmlp_pkg::FIDX_W-1:0]  idx,
  output fpmlp_pkg::div_res_t           res
);
  import fpmlp_pkg::*;

  div_t             head_r;
  div_t             head_nxt;
  div_t             link [0:DIV_CELLS];
  logic             below;
  logic             sneg;
  logic [VAL_W-1:0] mag;
  logic [VAL_W-1:0] smag;
  logic [WORD_W-1:0] q32;

  always_comb begin
    below    = $signed(x) < $signed(mean);
    mag      = below ? (mean - x) : (x - mean);
    sneg     = scale[VAL_W-1];
    smag     = sneg ? (VAL_W'(0) - scale) : scale;
    head_nxt = '0;
    head_nxt.vld  = go;
    head_nxt.num  = mag << FRAC_BITS;
    head_nxt.den  = smag;
    head_nxt.neg  = below ^ sneg;
    head_nxt.zero = (smag == '0);
    head_nxt.idx  = idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  assign link[0] = head_r;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
    fpmlp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (link[g]),
      .cell_out (link[g+1])
    );
  end

  always_comb begin
    q32 = link[DIV_CELLS].quo[WORD_W-1:0];
    if (link[DIV_CELLS].neg) begin
      q32 = WORD_W'(0) - q32;
    end
    if (link[DIV_CELLS].zero) begin
      q32 = '0;
    end
    res.vld = link[DIV_CELLS].vld;
    res.idx = link[DIV_CELLS].idx;
    res.val = q32;
  end

endmodule

FILE: rtl/core/fixed_point_mlp_classifier.sv
// Fixed-point MLP classifier. Beats with tuser set to a load operation fill the feature means
// and scales, the biases and the weights, one entry per beat. A feature sample beat is
// standard-scaled through a chain of 64 restoring-division cells, and the block takes no
// further beat until the scaled feature has been stored. A sample beat with tlast set then runs
// the three dense layers on one shared multiply-accumulate pipeline, one product per cycle
// except while it drains between layers, after which the result beat, carrying the two logits
// and the winning class, appears on the output.
module fixed_point_mlp_classifier #(
  parameter int N_FEATURES    = fpmlp_pkg::DEF_N_FEATURES,
  parameter int HIDDEN_FIRST  = fpmlp_pkg::DEF_HIDDEN_FIRST,
  parameter int HIDDEN_SECOND = fpmlp_pkg::DEF_HIDDEN_SECOND,
  parameter int FRAC_BITS     = fpmlp_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // index [10:0], value [74:11], zero [79:75]
  input  logic [2:0]  in_tuser,   // operation [2:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // class_index [0], logit_zero [32:1], logit_one [64:33]
);
  import fpmlp_pkg::*;

  localparam int WDEPTH  = HIDDEN_FIRST * N_FEATURES + HIDDEN_SECOND * HIDDEN_FIRST
                           + N_CLASSES * HIDDEN_SECOND;
  localparam int BDEPTH  = HIDDEN_FIRST + HIDDEN_SECOND + N_CLASSES;
  localparam int WA_W    = addr_w(WDEPTH);
  localparam int BA_W    = addr_w(BDEPTH);
  localparam int FA_W    = addr_w(N_FEATURES);
  localparam int H1_W    = addr_w(HIDDEN_FIRST);
  localparam int H2_W    = addr_w(HIDDEN_SECOND);
  localparam int DIM_A   = (N_FEATURES > HIDDEN_FIRST) ? N_FEATURES : HIDDEN_FIRST;
  localparam int DIM_B   = (HIDDEN_SECOND > N_CLASSES) ? HIDDEN_SECOND : N_CLASSES;
  localparam int DIM_MAX = (DIM_A > DIM_B) ? DIM_A : DIM_B;
  localparam int CNT_W   = addr_w(DIM_MAX);
  localparam int WAIT_W  = 7;
  localparam logic [WAIT_W-1:0] SCALE_WAIT = WAIT_W'(DIV_CELLS + 3);
  localparam logic [WAIT_W-1:0] DRAIN_WAIT = WAIT_W'(6);
  localparam logic [CNT_W-1:0]  COLS0 = CNT_W'(N_FEATURES - 1);
  localparam logic [CNT_W-1:0]  COLS1 = CNT_W'(HIDDEN_FIRST - 1);
  localparam logic [CNT_W-1:0]  COLS2 = CNT_W'(HIDDEN_SECOND - 1);
  localparam logic [CNT_W-1:0]  ROWS0 = CNT_W'(HIDDEN_FIRST - 1);
  localparam logic [CNT_W-1:0]  ROWS1 = CNT_W'(HIDDEN_SECOND - 1);
  localparam logic [CNT_W-1:0]  ROWS2 = CNT_W'(N_CLASSES - 1);
  localparam logic [VAL_W-1:0]  HALF  = VAL_W'(1) << (FRAC_BITS - 1);

  logic [IDX_W-1:0]  in_index;
  logic [VAL_W-1:0]  in_value;
  op_t               in_op;
  logic              fire_in;
  logic [FA_W-1:0]   fidx;

  logic [VAL_W-1:0]  mean_mem  [0:N_FEATURES-1];
  logic [VAL_W-1:0]  scale_mem [0:N_FEATURES-1];
  logic [WORD_W-1:0] w_mem     [0:WDEPTH-1];
  logic [WORD_W-1:0] b_mem     [0:BDEPTH-1];
  logic [WORD_W-1:0] h1_mem    [0:HIDDEN_FIRST-1];
  logic [WORD_W-1:0] h2_mem    [0:HIDDEN_SECOND-1];
  logic [WORD_W-1:0] sf_r      [0:N_FEATURES-1];
  logic [N_FEATURES-1:0] sfv_r;

  logic [VAL_W-1:0]  mean_rd_r;
  logic [VAL_W-1:0]  scale_rd_r;
  logic [VAL_W-1:0]  x_r;
  logic [FIDX_W-1:0] sidx_r;
  logic              go_r;
  logic              last_r;
  div_res_t          dres;

  state_t            state_r, state_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  layer_t            layer_r, layer_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [WA_W-1:0]   waddr_r, waddr_nxt;
  logic [BA_W-1:0]   baddr_r, baddr_nxt;
  logic              issue;
  logic              load_out;
  logic [CNT_W-1:0]  cols_last;
  logic [CNT_W-1:0]  rows_last;

  logic              v1_r, first1_r, last1_r;
  layer_t            layer1_r;
  logic [CNT_W-1:0]  row1_r;
  logic [WORD_W-1:0] w1_r, sf1_r, h1rd_r, h2rd_r, b1_r;
  logic [WORD_W-1:0] xsel;
  logic              v2_r, first2_r, last2_r;
  layer_t            layer2_r;
  logic [CNT_W-1:0]  row2_r;
  logic [WORD_W-1:0] b2_r;
  logic [VAL_W-1:0]  prod2_r;
  logic              done3_r;
  layer_t            layer3_r;
  logic [CNT_W-1:0]  row3_r;
  logic [WORD_W-1:0] b3_r;
  logic [VAL_W-1:0]  acc3_r;
  logic [VAL_W-1:0]  rsum;
  logic [VAL_W-1:0]  rshift;
  logic              done4_r;
  layer_t            layer4_r;
  logic [CNT_W-1:0]  row4_r;
  logic [WORD_W-1:0] b4_r;
  logic [WORD_W-1:0] rnd4_r;
  logic [WORD_W-1:0] y5;
  logic [WORD_W-1:0] logit0_r, logit1_r;

  logic              out_valid_r, out_valid_nxt;
  logic              cls_r;
  logic [WORD_W-1:0] out_l0_r, out_l1_r;

  assign in_index = in_tdata[IDX_W-1:0];
  assign in_value = in_tdata[IDX_W+VAL_W-1:IDX_W];
  assign in_op    = op_t'(in_tuser);
  assign fire_in  = in_tvalid && in_tready;
  assign fidx     = in_index[FA_W-1:0];

  always_ff @(posedge clk) begin
    if (fire_in && in_op == OP_MEAN && in_index < N_FEATURES) begin
      mean_mem[fidx] <= in_value;
    end
    mean_rd_r <= mean_mem[fidx];
  end

  always_ff @(posedge clk) begin
    if (fire_in && in_op == OP_SCALE && in_index < N_FEATURES) begin
      scale_mem[fidx] <= in_value;
    end
    scale_rd_r <= scale_mem[fidx];
  end

  always_ff @(posedge clk) begin
    if (fire_in && in_op == OP_WEIGHT && in_index < WDEPTH) begin
      w_mem[WA_W'(in_index)] <= in_value[WORD_W-1:0];
    end
    w1_r <= w_mem[waddr_r];
  end

  always_ff @(posedge clk) begin
    if (fire_in && in_op == OP_BIAS && in_index < BDEPTH) begin
      b_mem[BA_W'(in_index)] <= in_value[WORD_W-1:0];
    end
    b1_r <= b_mem[baddr_r];
  end

  always_ff @(posedge clk) begin
    x_r    <= in_value;
    sidx_r <= FIDX_W'(in_index);
    if (!rst_n) begin
      go_r   <= 1'b0;
      last_r <= 1'b0;
    end else begin
      go_r <= fire_in && in_op == OP_SAMPLE && in_index < N_FEATURES;
      if (fire_in && in_op == OP_SAMPLE) begin
        last_r <= in_tlast;
      end
    end
  end

  fpmlp_div_chain #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .x     (x_r),
    .mean  (mean_rd_r),
    .scale (scale_rd_r),
    .idx   (sidx_r),
    .res   (dres)
  );

  always_ff @(posedge clk) begin
    if (dres.vld) begin
      sf_r[dres.idx[FA_W-1:0]] <= dres.val;
    end
    if (!rst_n) begin
      sfv_r <= '0;
    end else if (dres.vld) begin
      sfv_r[dres.idx[FA_W-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    case (layer_r)
      LAYER_IN: begin
        cols_last = COLS0;
        rows_last = ROWS0;
      end
      LAYER_MID: begin
        cols_last = COLS1;
        rows_last = ROWS1;
      end
      default: begin
        cols_last = COLS2;
        rows_last = ROWS2;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    layer_nxt = layer_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    waddr_nxt = waddr_r;
    baddr_nxt = baddr_r;
    issue     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (fire_in && in_op == OP_SAMPLE) begin
          state_nxt = ST_SCALE;
          wait_nxt  = '0;
        end
      end
      ST_SCALE: begin
        wait_nxt = wait_r + 1'b1;
        if (wait_r == SCALE_WAIT) begin
          if (last_r) begin
            state_nxt = ST_MAC;
            layer_nxt = LAYER_IN;
            row_nxt   = '0;
            col_nxt   = '0;
            waddr_nxt = '0;
            baddr_nxt = '0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MAC: begin
        issue     = 1'b1;
        waddr_nxt = waddr_r + 1'b1;
        col_nxt   = col_r + 1'b1;
        if (col_r == cols_last) begin
          col_nxt   = '0;
          row_nxt   = row_r + 1'b1;
          baddr_nxt = baddr_r + 1'b1;
          if (row_r == rows_last) begin
            row_nxt   = '0;
            state_nxt = ST_DRAIN;
            wait_nxt  = '0;
          end
        end
      end
      ST_DRAIN: begin
        wait_nxt = wait_r + 1'b1;
        if (wait_r == DRAIN_WAIT) begin
          if (layer_r == LAYER_OUT) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_MAC;
            layer_nxt = (layer_r == LAYER_IN) ? LAYER_MID : LAYER_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= '0;
      layer_r <= LAYER_IN;
      row_r   <= '0;
      col_r   <= '0;
      waddr_r <= '0;
      baddr_r <= '0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      layer_r <= layer_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      waddr_r <= waddr_nxt;
      baddr_r <= baddr_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    sf1_r    <= sfv_r[col_r[FA_W-1:0]] ? sf_r[col_r[FA_W-1:0]] : '0;
    h1rd_r   <= h1_mem[col_r[H1_W-1:0]];
    h2rd_r   <= h2_mem[col_r[H2_W-1:0]];
    first1_r <= (col_r == '0);
    last1_r  <= (col_r == cols_last);
    layer1_r <= layer_r;
    row1_r   <= row_r;
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= issue;
    end
  end

  always_comb begin
    case (layer1_r)
      LAYER_IN:  xsel = sf1_r;
      LAYER_MID: xsel = h1rd_r;
      default:   xsel = h2rd_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod2_r  <= VAL_W'($signed(w1_r) * $signed(xsel));
    first2_r <= first1_r;
    last2_r  <= last1_r;
    layer2_r <= layer1_r;
    row2_r   <= row1_r;
    b2_r     <= b1_r;
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc3_r <= (first2_r ? VAL_W'(0) : acc3_r) + prod2_r;
    end
    layer3_r <= layer2_r;
    row3_r   <= row2_r;
    b3_r     <= b2_r;
    if (!rst_n) begin
      done3_r <= 1'b0;
    end else begin
      done3_r <= v2_r && last2_r;
    end
  end

  assign rsum   = acc3_r + HALF;
  assign rshift = VAL_W'($signed(rsum) >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    rnd4_r   <= rshift[WORD_W-1:0];
    layer4_r <= layer3_r;
    row4_r   <= row3_r;
    b4_r     <= b3_r;
    if (!rst_n) begin
      done4_r <= 1'b0;
    end else begin
      done4_r <= done3_r;
    end
  end

  always_comb begin
    y5 = rnd4_r + b4_r;
    if (layer4_r != LAYER_OUT && y5[WORD_W-1]) begin
      y5 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (done4_r && layer4_r == LAYER_IN) begin
      h1_mem[row4_r[H1_W-1:0]] <= y5;
    end
  end

  always_ff @(posedge clk) begin
    if (done4_r && layer4_r == LAYER_MID) begin
      h2_mem[row4_r[H2_W-1:0]] <= y5;
    end
  end

  always_ff @(posedge clk) begin
    if (done4_r && layer4_r == LAYER_OUT) begin
      if (row4_r == '0) begin
        logit0_r <= y5;
      end else begin
        logit1_r <= y5;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_l0_r <= logit0_r;
      out_l1_r <= logit1_r;
      cls_r    <= !($signed(logit0_r) > $signed(logit1_r));
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_l1_r, out_l0_r, cls_r};

`ifndef SYNTH
  a_div_only_when_scaling: assert property (@(posedge clk) disable iff (!rst_n)
    dres.vld |-> state_r == ST_SCALE)
    else $error("division result outside the scaling window");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_OUT)
    else $error("result raised without a finished inference");

  a_class_matches_logits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cls_r == !($signed(out_l0_r) > $signed(out_l1_r)))
    else $error("class index disagrees with logits");

  a_no_issue_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> !$past(in_tready))
    else $error("multiply issued while accepting beats");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import fpmlp_pkg::*;

  localparam int NF = DEF_N_FEATURES;
  localparam int H1 = DEF_HIDDEN_FIRST;
  localparam int H2 = DEF_HIDDEN_SECOND;
  localparam int FB = DEF_FRAC_BITS;
  localparam int W2_BASE = H1 * NF;
  localparam int W3_BASE = W2_BASE + H2 * H1;
  localparam int W_DEPTH = W3_BASE + N_CLASSES * H2;
  localparam int B2_BASE = H1;
  localparam int B3_BASE = H1 + H2;
  localparam int B_DEPTH = B3_BASE + N_CLASSES;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_LAST = 3'd7;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 4000;
  localparam int SETTLE_CYCLES = 1300;

  typedef struct {
    logic [2:0]  op;
    logic [10:0] idx;
    logic [63:0] val;
    logic        last;
  } beat_t;

  typedef struct {
    logic        cls;
    logic [31:0] l0;
    logic [31:0] l1;
  } logits_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  beat_t   beats_pending[$];
  logits_t logits_due[$];
  int      send_idle_pct = 19;
  int      recv_idle_pct = 63;
  logic    hold_req = 1'b0;
  int      hold_left = 0;
  int      stall_cycles = 0;
  int      errors = 0;

  logic [63:0] mean_mem[NF];
  logic [63:0] scale_mem[NF];
  logic [31:0] weight_mem[W_DEPTH];
  logic [31:0] bias_mem[B_DEPTH];
  logic [31:0] scaled_mem[NF];

  fixed_point_mlp_classifier uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] std_scale(logic [63:0] x, logic [63:0] mean,
                                            logic [63:0] sc);
    logic        below;
    logic [63:0] mag;
    logic [63:0] smag;
    logic [63:0] q;
    below = $signed(x) < $signed(mean);
    mag = below ? mean - x : x - mean;
    smag = sc[63] ? 64'd0 - sc : sc;
    if (smag == 64'd0) return 32'd0;
    q = (mag << FB) / smag;
    if (below != sc[63]) q = 64'd0 - q;
    return q[31:0];
  endfunction

  function automatic logic [31:0] neuron(int wbase, int bidx, int cols,
                                         logic [31:0] src[$], bit relu);
    longint acc;
    logic [31:0] r;
    acc = 0;
    for (int j = 0; j < cols; j++) begin
      acc += longint'($signed(weight_mem[wbase + j])) * longint'($signed(src[j]));
    end
    acc = (acc + (64'sd1 <<< (FB - 1))) >>> FB;
    acc += longint'($signed(bias_mem[bidx]));
    r = acc[31:0];
    if (relu && r[31]) r = 32'd0;
    return r;
  endfunction

  task automatic apply_beat(beat_t b);
    logic [31:0] layer_a[$];
    logic [31:0] layer_b[$];
    logits_t     res;
    case (b.op)
      OP_MEAN:   if (b.idx < NF) mean_mem[b.idx] = b.val;
      OP_SCALE:  if (b.idx < NF) scale_mem[b.idx] = b.val;
      OP_BIAS:   if (b.idx < B_DEPTH) bias_mem[b.idx] = b.val[31:0];
      OP_WEIGHT: if (b.idx < W_DEPTH) weight_mem[b.idx] = b.val[31:0];
      OP_SAMPLE: begin
        if (b.idx < NF) scaled_mem[b.idx] = std_scale(b.val, mean_mem[b.idx], scale_mem[b.idx]);
        if (b.last) begin
          for (int i = 0; i < NF; i++) layer_b.push_back(scaled_mem[i]);
          for (int i = 0; i < H1; i++) layer_a.push_back(neuron(i * NF, i, NF, layer_b, 1'b1));
          layer_b = {};
          for (int i = 0; i < H2; i++) begin
            layer_b.push_back(neuron(W2_BASE + i * H1, B2_BASE + i, H1, layer_a, 1'b1));
          end
          res.l0 = neuron(W3_BASE, B3_BASE, H2, layer_b, 1'b0);
          res.l1 = neuron(W3_BASE + H2, B3_BASE + 1, H2, layer_b, 1'b0);
          res.cls = ($signed(res.l0) > $signed(res.l1)) ? 1'b0 : 1'b1;
          logits_due.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        apply_beat('{in_tuser, in_tdata[10:0], in_tdata[74:11], in_tlast});
      end
      if (beats_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nb = beats_pending.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nb.op;
        in_tdata <= {5'd0, nb.val, nb.idx};
        in_tlast <= nb.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logits_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_req) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      out_tready <= !hold_req && hold_left <= 1 && $urandom_range(99) >= recv_idle_pct;
      if (out_tvalid && out_tready) begin
        if (logits_due.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_tdata);
          errors++;
        end else begin
          e = logits_due.pop_front();
          if (out_tdata[0] !== e.cls) begin
            $display("%0t: class_index expected %0d actual %0d", $time, e.cls, out_tdata[0]);
            errors++;
          end
          if (out_tdata[32:1] !== e.l0) begin
            $display("%0t: logit_zero expected %h actual %h", $time, e.l0, out_tdata[32:1]);
            errors++;
          end
          if (out_tdata[64:33] !== e.l1) begin
            $display("%0t: logit_one expected %h actual %h", $time, e.l1, out_tdata[64:33]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    case ($urandom_range(3))
      0: v = {$urandom, $urandom};
      1: v = 64'($signed(32'($urandom_range(0, 1 << 22)) - (1 << 21)));
      default: v = 64'($signed(32'($urandom_range(0, 1 << 20)) - (1 << 19)));
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_weight();
    if ($urandom_range(15) == 0) return {$urandom, $urandom};
    return 64'($signed(32'($urandom_range(0, 1 << 16)) - (1 << 15)));
  endfunction

  function automatic logic [63:0] rand_scale();
    case ($urandom_range(15))
      0: return 64'd0;
      1: return {$urandom, $urandom};
      2: return 64'd0 - 64'($urandom_range(1, 1 << 20));
      default: return 64'($urandom_range(1 << 12, 1 << 20));
    endcase
  endfunction

  task automatic push(logic [2:0] op, int idx, logic [63:0] val, logic last);
    beats_pending.push_back('{op, 11'(idx), val, last});
  endtask

  task automatic drain();
    while (beats_pending.size() != 0 || in_tvalid || logits_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic push_frame();
    int n;
    n = $urandom_range(1, 20);
    for (int k = 0; k < n; k++) begin
      push(OP_SAMPLE, $urandom_range(NF - 1), rand_value(), k == n - 1);
    end
  endtask

  task automatic push_random(int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        push_frame();
        sent += 10;
      end else if (pick < 78) begin
        push(OP_MEAN, $urandom_range(NF - 1), rand_value(), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 84) begin
        push(OP_SCALE, $urandom_range(NF - 1), rand_scale(), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 88) begin
        push(OP_BIAS, $urandom_range(B_DEPTH - 1), rand_value(), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 93) begin
        push(OP_WEIGHT, $urandom_range(W_DEPTH - 1), rand_weight(), 1'($urandom_range(1)));
        sent++;
      end else begin
        push(3'($urandom_range(OP_MEAN, OP_UNUSED_LAST)), $urandom_range(NF, 2047),
             {$urandom, $urandom}, 1'($urandom_range(1)));
        push($urandom_range(1) ? OP_UNUSED_FIRST : OP_UNUSED_LAST, $urandom,
             {$urandom, $urandom}, 1'($urandom_range(1)));
        sent += 2;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NF; i++) scaled_mem[i] = 32'd0;
    for (int i = 0; i < NF; i++) begin
      push(OP_MEAN, i, rand_value(), 1'b0);
      push(OP_SCALE, i, (i == 3) ? 64'd0 : (i == 5) ? -64'sd70000 : rand_scale(), 1'b0);
    end
    for (int i = 0; i < B_DEPTH; i++) push(OP_BIAS, i, rand_value(), 1'b0);
    for (int i = 0; i < W_DEPTH; i++) push(OP_WEIGHT, i, rand_weight(), 1'b0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    push(OP_SAMPLE, 0, 64'h7fff_ffff_ffff_ffff, 1'b0);
    push(OP_SAMPLE, 1, 64'h8000_0000_0000_0000, 1'b0);
    push(OP_SAMPLE, 2, 64'h4000_0000_0000_0000, 1'b0);
    push(OP_SAMPLE, 3, 64'd12345, 1'b0);
    push(OP_SAMPLE, 5, -64'sd300000, 1'b0);
    push(OP_SAMPLE, 2047, 64'hffff_ffff_ffff_ffff, 1'b0);
    push(OP_UNUSED_FIRST, 0, 64'd1, 1'b1);
    push(OP_UNUSED_MID, 1, 64'd1, 1'b1);
    push(OP_UNUSED_LAST, 2047, 64'd1, 1'b1);
    push(OP_MEAN, 2047, 64'd7, 1'b1);
    push(OP_WEIGHT, 2047, 64'd7, 1'b1);
    push(OP_BIAS, B_DEPTH, 64'd7, 1'b1);
    push(OP_SAMPLE, 15, 64'd0, 1'b1);
    push(OP_SAMPLE, NF, 64'd99, 1'b1);
    for (int i = 0; i < N_CLASSES * H2; i++) push(OP_WEIGHT, W3_BASE + i, 64'd0, 1'b0);
    push(OP_BIAS, B3_BASE, 64'd5, 1'b0);
    push(OP_BIAS, B3_BASE + 1, 64'd5, 1'b0);
    push(OP_SAMPLE, 4, 64'd1000, 1'b1);
    push(OP_BIAS, B3_BASE, 64'd9, 1'b0);
    push(OP_BIAS, B3_BASE + 1, -64'sd9, 1'b0);
    push(OP_SAMPLE, 4, 64'd1000, 1'b1);
    for (int i = 0; i < N_CLASSES * H2; i++) push(OP_WEIGHT, W3_BASE + i, rand_weight(), 1'b0);
    push_random(150);
    drain();

    send_idle_pct = 63;
    recv_idle_pct = 19;
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int k = 0; k < 4; k++) push(OP_SAMPLE, $urandom_range(NF - 1), rand_value(), 1'b1);
    push_random(170);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(180);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/fpmlp_pkg.sv
rtl/core/fpmlp_div_cell.sv
rtl/core/fpmlp_div_chain.sv
rtl/core/fixed_point_mlp_classifier.sv
tb/tb.sv
